### sv/pnns_pkg.sv
`default_nettype none

package pnns_pkg;

	localparam int SRC_WIDTH       = 320;
	localparam int SRC_HEIGHT      = 200;
	localparam int PALETTE_ENTRIES = 256;
	localparam int COLOUR_BYTES    = 4;

	localparam int COORD_W  = 11;
	localparam int INDEX_W  = 8;
	localparam int COLOUR_W = 32;

	localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
	localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
	localparam int PAL_AW      = $clog2(PALETTE_ENTRIES);

	localparam int SX_W   = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
	localparam int SY_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
	localparam int QUOT_W = (SX_W > SY_W) ? SX_W : SY_W;
	localparam int DIV_W  = COORD_W + QUOT_W + 1;

	localparam logic [COLOUR_W-1:0] COLOUR_MASK =
		COLOUR_W'((64'd1 << (8 * COLOUR_BYTES)) - 64'd1);

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;

	localparam logic [1:0] FUNC_PAL_WR = 2'd0;
	localparam logic [1:0] FUNC_PIX_WR = 2'd1;
	localparam logic [1:0] FUNC_REQ    = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

	localparam logic [COORD_W-1:0] OUT_WIDTH_RST  = 11'd320;
	localparam logic [COORD_W-1:0] OUT_HEIGHT_RST = 11'd200;

	typedef struct packed {
		logic [1:0]          func;
		logic                hit;
		logic [COORD_W-1:0]  px;
		logic [COORD_W-1:0]  py;
		logic [INDEX_W-1:0]  entry;
		logic [COLOUR_W-1:0] colour;
		logic [INDEX_W-1:0]  pix;
	} item_t;

endpackage

`default_nettype wire

### sv/pnns_div.sv
`default_nettype none

module pnns_div (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [pnns_pkg::DIV_W-1:0]     dividend,
	input  wire logic [pnns_pkg::COORD_W-1:0]   divisor,
	output logic      [pnns_pkg::QUOT_W-1:0]    quotient
);

	localparam int QW = pnns_pkg::QUOT_W;
	localparam int DW = pnns_pkg::DIV_W;

	logic [DW-1:0] rem_q [0:QW-1];
	logic [QW-1:0] quo_q [0:QW];
	logic [DW-1:0] trial [0:QW-1];
	logic [QW-1:0] ge;

	// One quotient bit per stage, most significant first.
	always_comb begin
		for (int i = 0; i < QW; i++) begin
			trial[i] = DW'(divisor) << (QW - 1 - i);
			ge[i]    = rem_q[i] >= trial[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= dividend;
			quo_q[0] <= '0;
			for (int i = 0; i < QW - 1; i++) begin
				rem_q[i+1] <= ge[i] ? (rem_q[i] - trial[i]) : rem_q[i];
			end
			for (int i = 0; i < QW; i++) begin
				quo_q[i+1] <= quo_q[i] | (QW'(ge[i]) << (QW - 1 - i));
			end
		end
	end

	assign quotient = quo_q[QW];

endmodule

`default_nettype wire

### sv/palette_nearest_neighbor_scaler_core.sv
`default_nettype none

// Channel   Direction  Handshake                    Content
// s_axis    in         s_axis_tvalid/s_axis_tready  write or pixel request, func in tuser
// m_axis    out        m_axis_tvalid/m_axis_tready  colour word, range flag in tuser
// cfg       in         cfg_valid/cfg_ready          output width and height registers
//
// One item is taken per cycle unless a result waits unaccepted; m_axis_tvalid rises once a
// request has passed the divider stages, the address stage, two memory stages and the output register.
// Each memory has one port and every item touches it in the same stage, so stored data
// is seen in item order with no forwarding. Reset clears the pipeline and sets the size
// registers; the stores have no clearing pass. When a result waits unaccepted, the whole
// pipeline holds.

module palette_nearest_neighbor_scaler_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// pos_x, pos_y, entry_index, colour_word, pixel_index, two zero bits
	input  wire logic [pnns_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// func
	input  wire logic [pnns_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// colour_out
	output logic      [pnns_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// out_of_range
	output logic                                     m_axis_tuser,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pnns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pnns_pkg::COORD_W-1:0]        cfg_data
);

	localparam int QW = pnns_pkg::QUOT_W;

	logic [pnns_pkg::COORD_W-1:0] out_width_q;
	logic [pnns_pkg::COORD_W-1:0] out_height_q;

	logic                        adv;
	logic                        in_fire;
	pnns_pkg::item_t             in_item;
	logic [pnns_pkg::DIV_W-1:0]  num_x;
	logic [pnns_pkg::DIV_W-1:0]  num_y;
	logic [QW-1:0]               quo_x;
	logic [QW-1:0]               quo_y;

	logic [QW:0]                 vld_q;
	pnns_pkg::item_t             side_q [0:QW];

	logic [QW-1:0]               col;
	logic [QW-1:0]               row;

	logic                        vld_sa;
	logic [1:0]                  func_sa;
	logic                        hit_sa;
	logic [pnns_pkg::FRAME_AW-1:0] addr_sa;
	logic [pnns_pkg::INDEX_W-1:0]  entry_sa;
	logic [pnns_pkg::COLOUR_W-1:0] colour_sa;
	logic [pnns_pkg::INDEX_W-1:0]  pix_sa;

	logic                        vld_sb;
	logic [1:0]                  func_sb;
	logic                        hit_sb;
	logic [pnns_pkg::INDEX_W-1:0]  entry_sb;
	logic [pnns_pkg::COLOUR_W-1:0] colour_sb;
	logic [pnns_pkg::INDEX_W-1:0]  frame_rd_sb;

	logic                        vld_sc;
	logic [1:0]                  func_sc;
	logic                        oor_sc;
	logic                        zero_sc;
	logic [pnns_pkg::COLOUR_W-1:0] pal_rd_sc;

	logic                        out_valid_q;
	logic [pnns_pkg::COLOUR_W-1:0] colour_q;
	logic                        oor_q;

	logic                        frame_we;
	logic                        pal_we;
	logic [pnns_pkg::PAL_AW-1:0] pal_addr;

	logic [pnns_pkg::INDEX_W-1:0]  frame_mem [0:pnns_pkg::FRAME_DEPTH-1];
	logic [pnns_pkg::COLOUR_W-1:0] pal_mem   [0:pnns_pkg::PALETTE_ENTRIES-1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= pnns_pkg::OUT_WIDTH_RST;
			out_height_q <= pnns_pkg::OUT_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pnns_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data;
				pnns_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_fire       = s_axis_tvalid && adv;

	always_comb begin
		in_item.func   = s_axis_tuser;
		in_item.px     = s_axis_tdata[10:0];
		in_item.py     = s_axis_tdata[21:11];
		in_item.entry  = s_axis_tdata[29:22];
		in_item.colour = s_axis_tdata[61:30] & pnns_pkg::COLOUR_MASK;
		in_item.pix    = s_axis_tdata[69:62];
		unique case (s_axis_tuser)
			pnns_pkg::FUNC_PAL_WR:
				in_item.hit = {1'b0, s_axis_tdata[29:22]} <
					(pnns_pkg::INDEX_W + 1)'(pnns_pkg::PALETTE_ENTRIES);
			pnns_pkg::FUNC_PIX_WR:
				in_item.hit = (s_axis_tdata[10:0] < pnns_pkg::COORD_W'(pnns_pkg::SRC_WIDTH))
					&& (s_axis_tdata[21:11] < pnns_pkg::COORD_W'(pnns_pkg::SRC_HEIGHT));
			pnns_pkg::FUNC_REQ:
				in_item.hit = (s_axis_tdata[10:0] < out_width_q)
					&& (s_axis_tdata[21:11] < out_height_q);
			default:
				in_item.hit = 1'b0;
		endcase
	end

	assign num_x = pnns_pkg::DIV_W'(s_axis_tdata[10:0])
		* pnns_pkg::DIV_W'(pnns_pkg::SRC_WIDTH);
	assign num_y = pnns_pkg::DIV_W'(s_axis_tdata[21:11])
		* pnns_pkg::DIV_W'(pnns_pkg::SRC_HEIGHT);

	pnns_div u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (num_x),
		.divisor  (out_width_q),
		.quotient (quo_x)
	);

	pnns_div u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (num_y),
		.divisor  (out_height_q),
		.quotient (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			vld_sa      <= 1'b0;
			vld_sb      <= 1'b0;
			vld_sc      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[QW-1:0], in_fire};
			vld_sa      <= vld_q[QW];
			vld_sb      <= vld_sa;
			vld_sc      <= vld_sb;
			out_valid_q <= vld_sc && (func_sc == pnns_pkg::FUNC_REQ);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= in_item;
			for (int i = 0; i < QW; i++) begin
				side_q[i+1] <= side_q[i];
			end
		end
	end

	// Pixel writes bypass the divider and address the frame directly.
	assign col = (side_q[QW].func == pnns_pkg::FUNC_PIX_WR) ? QW'(side_q[QW].px) : quo_x;
	assign row = (side_q[QW].func == pnns_pkg::FUNC_PIX_WR) ? QW'(side_q[QW].py) : quo_y;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_sa   <= side_q[QW].func;
			hit_sa    <= side_q[QW].hit;
			addr_sa   <= pnns_pkg::FRAME_AW'(row) * pnns_pkg::FRAME_AW'(pnns_pkg::SRC_WIDTH)
				+ pnns_pkg::FRAME_AW'(col);
			entry_sa  <= side_q[QW].entry;
			colour_sa <= side_q[QW].colour;
			pix_sa    <= side_q[QW].pix;
		end
	end

	assign frame_we = adv && vld_sa && hit_sa && (func_sa == pnns_pkg::FUNC_PIX_WR);

	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[addr_sa] <= pix_sa;
		end
		if (adv) begin
			frame_rd_sb <= frame_mem[addr_sa];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_sb   <= func_sa;
			hit_sb    <= hit_sa;
			entry_sb  <= entry_sa;
			colour_sb <= colour_sa;
		end
	end

	assign pal_we   = adv && vld_sb && hit_sb && (func_sb == pnns_pkg::FUNC_PAL_WR);
	assign pal_addr = (func_sb == pnns_pkg::FUNC_PAL_WR) ? entry_sb[pnns_pkg::PAL_AW-1:0]
		: frame_rd_sb[pnns_pkg::PAL_AW-1:0];

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_addr] <= colour_sb;
		end
		if (adv) begin
			pal_rd_sc <= pal_mem[pal_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_sc <= func_sb;
			oor_sc  <= !hit_sb;
			zero_sc <= !hit_sb || ({1'b0, frame_rd_sb} >=
				(pnns_pkg::INDEX_W + 1)'(pnns_pkg::PALETTE_ENTRIES));
			colour_q <= zero_sc ? '0 : pal_rd_sc;
			oor_q    <= oor_sc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = colour_q;
	assign m_axis_tuser  = oor_q;

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out-of-range result carries a non-zero colour");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[QW] && (side_q[QW].func == pnns_pkg::FUNC_REQ) && side_q[QW].hit
		|-> (quo_x < pnns_pkg::SRC_WIDTH) && (quo_y < pnns_pkg::SRC_HEIGHT))
		else $error("mapped source position lies outside the source frame");

	a_frame_addr: assert property (@(posedge clk) disable iff (!arst_n)
		frame_we |-> addr_sa < pnns_pkg::FRAME_DEPTH)
		else $error("frame write beyond the frame store");

	a_req_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_sc && (func_sc == pnns_pkg::FUNC_REQ) |=> m_axis_tvalid)
		else $error("request reached the last stage but produced no result");

endmodule

`default_nettype wire
